/* sv/mec_pkg.sv */
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants for the escape-time color block
// Field widths, register reset value and result codes.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int C_W     = 31;  // width of one part of c
  localparam int Z_W     = 32;  // width of one part of z
  localparam int P_W     = 2 * Z_W;
  localparam int ITER_W  = 16;
  localparam int COLOR_W = 8;

  localparam logic [ITER_W-1:0]  MAX_ITER_RESET = ITER_W'(10000);
  localparam logic [COLOR_W-1:0] COLOR_INSIDE   = COLOR_W'(255);
  localparam logic [COLOR_W-1:0] COLOR_MOD_TOP  = COLOR_W'(254);

  typedef logic signed [C_W-1:0] c_part_t;
  typedef logic signed [Z_W-1:0] z_part_t;
  typedef logic signed [P_W-1:0] prod_t;
  typedef logic [ITER_W-1:0]     iter_t;
  typedef logic [COLOR_W-1:0]    color_t;

endpackage

/* sv/mec_if.sv */
// ----------------------------------------------------------------------------
// mec_in_if / mec_out_if: valid-ready channels of the escape-time block
// Input carries one point c, output carries one color index.
// ----------------------------------------------------------------------------
interface mec_in_if import mec_pkg::*; ();
  logic    valid;
  logic    ready;
  c_part_t c_real;
  c_part_t c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mec_out_if import mec_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t color_index;

  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

/* sv/mec_mul.sv */
// ----------------------------------------------------------------------------
// mec_mul: shared signed multiplier
// Full-width product of two z parts, registered on every clock.
// ----------------------------------------------------------------------------
module mec_mul import mec_pkg::*; (
  input  logic    clk,
  input  z_part_t op_a,
  input  z_part_t op_b,
  output prod_t   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= P_W'(op_a) * P_W'(op_b);
  end

endmodule

/* sv/mandelbrot_escape_color.sv */
// Flow: an accepted point runs n iterations (escape index + 1, or max_iter;
//   0 allowed), then S_DONE loads the output register once it is free.
// Input: no new point is taken until the result is loaded; each iteration uses the
//   shared multiplier three times (x*x, y*y, x*y), then S_UPDATE updates z.
// Reset: synchronous active low; max_iter returns to 10000, no result pending.
// ----------------------------------------------------------------------------
// mandelbrot_escape_color: escape-time color index for one point c
// Iterates z = z^2 + c in fixed point through one shared multiplier.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color import mec_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  mec_in_if.sink            in_ch,
  mec_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata
);

  localparam int SUM_W   = P_W - FRAC_BITS + 3;
  localparam int MAG_LSB = 2 * FRAC_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_XX, S_MUL_YY, S_MUL_XY, S_UPDATE, S_DONE
  } state_t;

  state_t  state_r;
  iter_t   max_iter_r;
  iter_t   iter_r;
  color_t  mod_r;
  color_t  color_r;
  color_t  color_out_r;
  logic    out_valid_r;
  c_part_t c_real_r;
  c_part_t c_imag_r;
  z_part_t z_real_r;
  z_part_t z_imag_r;
  prod_t   xx_r;
  prod_t   yy_r;
  prod_t   prod_r;

  z_part_t op_a;
  z_part_t op_b;

  logic signed [SUM_W-1:0] re_sum;
  logic signed [SUM_W-1:0] im_sum;
  logic [P_W-1:0]          mag;
  logic                    escape;
  logic                    last_iter;
  z_part_t                 z_real_nxt;
  z_part_t                 z_imag_nxt;

  mec_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // operand select for the shared multiplier
  always_comb begin
    op_a = z_real_r;
    op_b = z_real_r;
    unique case (state_r)
      S_MUL_YY: begin
        op_a = z_imag_r;
        op_b = z_imag_r;
      end
      S_MUL_XY: begin
        op_a = z_real_r;
        op_b = z_imag_r;
      end
      default: begin
        op_a = z_real_r;
        op_b = z_real_r;
      end
    endcase
  end

  function automatic z_part_t sat_z(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:Z_W-1] == {(SUM_W-Z_W+1){v[SUM_W-1]}});
    if (fits) begin
      return v[Z_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

  // prod_r holds x*y in S_UPDATE
  always_comb begin
    re_sum = SUM_W'(xx_r >>> FRAC_BITS) - SUM_W'(yy_r >>> FRAC_BITS)
           + SUM_W'(c_real_r);
    im_sum = SUM_W'(prod_r >>> (FRAC_BITS - 1)) + SUM_W'(c_imag_r);
    z_real_nxt = sat_z(re_sum);
    z_imag_nxt = sat_z(im_sum);
    mag        = $unsigned(xx_r) + $unsigned(yy_r);
    escape     = |mag[P_W-1:MAG_LSB];
    last_iter  = ((iter_r + ITER_W'(1)) == max_iter_r);
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.color_index = color_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= MAX_ITER_RESET;
    end else begin
      if (cfg_we) begin
        max_iter_r <= cfg_wdata;
      end
      // S_DONE refills the output register itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            c_real_r <= in_ch.c_real;
            c_imag_r <= in_ch.c_imag;
            z_real_r <= '0;
            z_imag_r <= '0;
            iter_r   <= '0;
            mod_r    <= '0;
            if (max_iter_r == '0) begin
              color_r <= COLOR_INSIDE;
              state_r <= S_DONE;
            end else begin
              state_r <= S_MUL_XX;
            end
          end
        end
        S_MUL_XX: begin
          state_r <= S_MUL_YY;
        end
        S_MUL_YY: begin
          xx_r    <= prod_r;
          state_r <= S_MUL_XY;
        end
        S_MUL_XY: begin
          yy_r    <= prod_r;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          z_real_r <= z_real_nxt;
          z_imag_r <= z_imag_nxt;
          if (escape) begin
            color_r <= mod_r;
            state_r <= S_DONE;
          end else if (last_iter) begin
            color_r <= COLOR_INSIDE;
            state_r <= S_DONE;
          end else begin
            iter_r  <= iter_r + ITER_W'(1);
            mod_r   <= (mod_r == COLOR_MOD_TOP) ? '0 : mod_r + COLOR_W'(1);
            state_r <= S_MUL_XX;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            color_out_r <= color_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/mec_checker.sv */
// ----------------------------------------------------------------------------
// mec_checker: port-level checks for the escape-time color block
// Watches handshakes and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker import mec_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input color_t color_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(color_index))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after a transaction");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared in the cycle after an input transaction");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the result and idle the block");

endmodule

bind mandelbrot_escape_color mec_checker u_mec_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .color_index (out_ch.color_index)
);

/* dv/mandelbrot_escape_color_test.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_test: self-checking bench for the escape-time block
// Drives points through the valid-ready input channel at several iteration
// limits and checks every color index against an in-bench predictor.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color_test import mec_pkg::*; ();

  localparam int FRAC_BITS     = 28;
  localparam int COLOR_MODULUS = 255;
  localparam longint unsigned ESCAPE_MAG = 64'd4 << (2 * FRAC_BITS);

  localparam int TWO_I     = 1 << (FRAC_BITS + 1);
  localparam int QUARTER_I = 1 << (FRAC_BITS - 2);

  localparam c_part_t C_ZERO = '0;
  localparam c_part_t C_TWO  = c_part_t'(TWO_I);
  localparam c_part_t C_NTWO = -c_part_t'(TWO_I);
  localparam c_part_t C_NONE = -c_part_t'(1 << FRAC_BITS);
  localparam c_part_t C_MAX  = {1'b0, {(C_W-1){1'b1}}};
  localparam c_part_t C_MIN  = {1'b1, {(C_W-1){1'b0}}};

  // Longest quiet stretch: a point inside the set at the largest limit,
  // with margin for receiver stalls.
  localparam int WATCHDOG_CYCLES = 3 * (4 * 65535 + 2) + 2000;
  localparam int END_CYCLES      = 20;

  class escape_scoreboard;
    iter_t  limit;
    color_t colors_due[$];
    int     errors;

    function new();
      limit  = MAX_ITER_RESET;
      errors = 0;
    endfunction

    function void set_limit(iter_t v);
      limit = v;
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (v < -longint'(33'sh0_8000_0000)) return -longint'(33'sh0_8000_0000);
      return v;
    endfunction

    function color_t escape_color(c_part_t cr, c_part_t ci);
      longint          zr, zi, xx, yy, xy, cre, cim;
      longint unsigned mag;
      int unsigned     n;
      cre = cr;
      cim = ci;
      zr  = 0;
      zi  = 0;
      for (n = 0; n < limit; n++) begin
        xx  = zr * zr;
        yy  = zi * zi;
        xy  = zr * zi;
        mag = xx + yy;
        // z is updated before the escape test on the old magnitude
        zr = clamp32((xx >>> FRAC_BITS) - (yy >>> FRAC_BITS) + cre);
        zi = clamp32((xy >>> (FRAC_BITS - 1)) + cim);
        if (mag >= ESCAPE_MAG) break;
      end
      if (n == limit) return COLOR_INSIDE;
      return color_t'(n % COLOR_MODULUS);
    endfunction

    function void note_point(c_part_t cr, c_part_t ci);
      colors_due.push_back(escape_color(cr, ci));
    endfunction

    function int pending();
      return colors_due.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] check failed: %s", $realtime, msg);
    endtask

    task check_color(color_t got);
      color_t want;
      if (colors_due.size() == 0) begin
        report($sformatf("unexpected color_index %0d", got));
      end else begin
        want = colors_due.pop_front();
        if (got !== want)
          report($sformatf("color_index got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  iter_t cfg_wdata;
  int    src_idle_pct;
  int    snk_idle_pct;
  int    quiet_cycles;

  escape_scoreboard sb;

  mec_in_if  in_ch ();
  mec_out_if out_ch ();

  mandelbrot_escape_color #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_color(out_ch.color_index);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leave valid high on return so back-to-back points need no re-raise.
  task automatic send_point(input c_part_t cr, input c_part_t ci);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.c_real <= cr;
    in_ch.c_imag <= ci;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_point(cr, ci);
  endtask

  // Hold off the sender until every outstanding color has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_limit(input iter_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic run_random(input int settings, input int per_setting);
    iter_t lim;
    int    cr;
    int    ci;
    for (int s = 0; s < settings; s++) begin
      case ($urandom_range(2))
        0:       lim = iter_t'($urandom_range(20));
        1:       lim = iter_t'($urandom_range(300, 21));
        default: lim = iter_t'($urandom_range(2000, 301));
      endcase
      drain_results();
      write_limit(lim);
      for (int k = 0; k < per_setting; k++) begin
        case ($urandom_range(9))
          7: begin
            // near the main cardioid: slow escapes and many inside points
            cr = int'($urandom_range(5 * QUARTER_I)) - 3 * QUARTER_I;
            ci = int'($urandom_range(6 * QUARTER_I)) - 3 * QUARTER_I;
          end
          8, 9: begin
            cr = int'($urandom);
            ci = int'($urandom);
          end
          default: begin
            cr = int'($urandom_range(2 * TWO_I)) - TWO_I;
            ci = int'($urandom_range(2 * TWO_I)) - TWO_I;
          end
        endcase
        send_point(c_part_t'(cr), c_part_t'(ci));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.c_real <= '0;
    in_ch.c_imag <= '0;
    src_idle_pct = 12;
    snk_idle_pct = 53;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: origin stays inside, edges of the field range escape
    send_point(C_ZERO, C_ZERO);
    send_point(C_NTWO, C_ZERO);
    send_point(C_TWO, C_TWO);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MIN);
    send_point(C_NTWO, C_NTWO);
    send_point(C_TWO, C_NTWO);

    // zero limit: every point reports inside
    drain_results();
    write_limit(iter_t'(0));
    send_point(C_ZERO, C_ZERO);
    send_point(C_MIN, C_MAX);

    drain_results();
    write_limit(iter_t'(1));
    send_point(C_ZERO, C_ZERO);
    send_point(C_TWO, C_TWO);

    drain_results();
    write_limit(iter_t'(2));
    send_point(C_TWO, C_TWO);
    send_point(C_NTWO, C_ZERO);

    // just right of the cusp at 1/4: escape counts around and past 255
    drain_results();
    write_limit(iter_t'(255));
    send_point(c_part_t'(QUARTER_I + (1 << 16)), C_ZERO);
    send_point(c_part_t'(QUARTER_I + (1 << 14)), C_ZERO);
    send_point(C_NONE, C_ZERO);

    drain_results();
    write_limit(iter_t'(16'hFFFF));
    send_point(c_part_t'(QUARTER_I + (1 << 14)), C_ZERO);
    send_point(c_part_t'(QUARTER_I + (1 << 8)), C_ZERO);
    send_point(C_ZERO, C_ZERO);

    run_random(3, 11);

    src_idle_pct = 53;
    snk_idle_pct = 12;
    run_random(3, 11);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(3, 11);

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
